/* hdl/fdss_pkg.sv */
package fdss_pkg;

    // Display driver register addresses and fixed data bytes
    localparam logic [3:0] ADDR_SHUTDOWN = 4'hC;
    localparam logic [3:0] ADDR_DECODE   = 4'h9;
    localparam logic [3:0] ADDR_SCANLIM  = 4'hB;
    localparam logic [7:0] DATA_SHUTDOWN = 8'h01;
    localparam logic [7:0] DATA_DECODE   = 8'h00;
    localparam logic [7:0] DATA_SCANLIM  = 8'h07;
    localparam logic [7:0] SEG_BLANK     = 8'h00;

    // Word slots of one frame
    localparam int          FRAME_WORDS = 7;
    localparam int          SLOT_W      = $clog2(FRAME_WORDS);
    localparam logic [SLOT_W-1:0] SLOT_SHUTDOWN = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_DECODE   = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_SCANLIM  = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_UNITS    = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SLOT_TENS     = SLOT_W'(4);
    localparam logic [SLOT_W-1:0] SLOT_HUNDREDS = SLOT_W'(5);
    localparam logic [SLOT_W-1:0] SLOT_LAST     = SLOT_W'(FRAME_WORDS - 1);

    // Digit registers of the high half start after this base
    localparam logic [3:0] UPPER_BASE = 4'd4;

    localparam int MODULUS = 10000;
    localparam int NUM_W   = 14;   // width of a value below the modulus
    localparam int REM_W   = 10;   // width of a remainder below one thousand

    typedef struct packed {
        logic [3:0]       digit;
        logic [REM_W-1:0] rest;
    } t_split;

    // Reduce a 16-bit value modulo 10000 by parallel compares
    function automatic logic [NUM_W-1:0] mod_frame(input logic [15:0] v);
        logic [2:0]  q;
        logic [15:0] r;
        q = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (v >= 16'(k * MODULUS)) begin
                q = 3'(k);
            end
        end
        r = v - 16'(16'(q) * 16'(MODULUS));
        return r[NUM_W-1:0];
    endfunction

    // Peel off one decimal digit of a given weight (value below ten weights)
    function automatic t_split split_digit(input logic [NUM_W-1:0] v, input int weight);
        t_split           s;
        logic [3:0]       d;
        logic [NUM_W-1:0] r;
        d = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (v >= NUM_W'(k * weight)) begin
                d = 4'(k);
            end
        end
        r       = v - NUM_W'(NUM_W'(d) * NUM_W'(weight));
        s.digit = d;
        s.rest  = r[REM_W-1:0];
        return s;
    endfunction

    // Segment pattern of one decimal digit
    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h7E;
            4'd1:    p = 8'h30;
            4'd2:    p = 8'h6D;
            4'd3:    p = 8'h79;
            4'd4:    p = 8'h33;
            4'd5:    p = 8'h5B;
            4'd6:    p = 8'h5F;
            4'd7:    p = 8'h70;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h7B;
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

endpackage

/* hdl/four_digit_seven_segment_frame_unit.sv */
// Turns a 16-bit number and a half select into a frame of seven display
// driver register words: shutdown=1, decode=0, scan limit=7, then the four
// digit registers (1..4, or 5..8 when i_upper_half is set), units first.
// The number is shown modulo 10000 with leading zeros blanked; the units
// digit always shows. A request passes three register stages (modulo,
// thousands, hundreds) and is then loaded into the frame register, which
// sends one word per cycle while i_ready is high. Up to three further
// requests queue in the stages while a frame is being sent.
module four_digit_seven_segment_frame_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_value,
    input  logic        i_upper_half,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_reg_address,
    output logic [7:0]  o_reg_data,
    output logic        o_last_word
);
    import fdss_pkg::*;

    // Stage registers
    logic                 r_v1, r_v2, r_v3;
    logic [NUM_W-1:0]     r_n1;
    logic                 r_u1, r_u2, r_u3;
    logic [3:0]           r_th2, r_th3, r_hu3;
    logic [REM_W-1:0]     r_rem2;
    logic [6:0]           r_rem3;

    // Frame register
    logic                 r_busy;
    logic [SLOT_W-1:0]    r_cnt;
    logic [7:0]           r_pat [4];
    logic                 r_upper;

    logic                 frame_free, ld, en1, en2, en3;
    t_split               s_th, s_hu, s_te;
    logic [7:0]           n_pat [4];
    logic                 th_zero, hu_zero, te_zero;

    // Stall chain from the output back to the input
    assign frame_free = !r_busy || (i_ready && (r_cnt == SLOT_LAST));
    assign ld         = r_v3 && frame_free;
    assign en3        = !r_v3 || frame_free;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_ready    = en1;

    // Digit splits per stage
    assign s_th = split_digit(r_n1, 1000);
    assign s_hu = split_digit(NUM_W'(r_rem2), 100);
    assign s_te = split_digit(NUM_W'(r_rem3), 10);

    // Blank leading zeros and look up patterns
    always_comb begin
        th_zero  = (r_th3 == 4'd0);
        hu_zero  = th_zero && (r_hu3 == 4'd0);
        te_zero  = hu_zero && (s_te.digit == 4'd0);
        n_pat[0] = seg_pattern(s_te.rest[3:0]);
        n_pat[1] = te_zero ? SEG_BLANK : seg_pattern(s_te.digit);
        n_pat[2] = hu_zero ? SEG_BLANK : seg_pattern(r_hu3);
        n_pat[3] = th_zero ? SEG_BLANK : seg_pattern(r_th3);
    end

    // Advance valid bits and the frame counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_busy <= 1'b0;
            r_cnt  <= SLOT_SHUTDOWN;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (ld) begin
                r_busy <= 1'b1;
                r_cnt  <= SLOT_SHUTDOWN;
            end else if (r_busy && i_ready) begin
                if (r_cnt == SLOT_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + SLOT_W'(1);
                end
            end
        end
    end

    // Move payload through the stages
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_n1 <= mod_frame(i_value);
            r_u1 <= i_upper_half;
        end
        if (en2) begin
            r_th2  <= s_th.digit;
            r_rem2 <= s_th.rest;
            r_u2   <= r_u1;
        end
        if (en3) begin
            r_th3  <= r_th2;
            r_hu3  <= s_hu.digit;
            r_rem3 <= s_hu.rest[6:0];
            r_u3   <= r_u2;
        end
        if (ld) begin
            for (int k = 0; k < 4; k++) begin
                r_pat[k] <= n_pat[k];
            end
            r_upper <= r_u3;
        end
    end

    // Select the current word of the frame
    always_comb begin
        o_valid     = r_busy;
        o_last_word = (r_cnt == SLOT_LAST);
        case (r_cnt)
            SLOT_SHUTDOWN: begin
                o_reg_address = ADDR_SHUTDOWN;
                o_reg_data    = DATA_SHUTDOWN;
            end
            SLOT_DECODE: begin
                o_reg_address = ADDR_DECODE;
                o_reg_data    = DATA_DECODE;
            end
            SLOT_SCANLIM: begin
                o_reg_address = ADDR_SCANLIM;
                o_reg_data    = DATA_SCANLIM;
            end
            SLOT_UNITS: begin
                o_reg_address = (r_upper ? UPPER_BASE : 4'd0) + 4'd1;
                o_reg_data    = r_pat[0];
            end
            SLOT_TENS: begin
                o_reg_address = (r_upper ? UPPER_BASE : 4'd0) + 4'd2;
                o_reg_data    = r_pat[1];
            end
            SLOT_HUNDREDS: begin
                o_reg_address = (r_upper ? UPPER_BASE : 4'd0) + 4'd3;
                o_reg_data    = r_pat[2];
            end
            SLOT_LAST: begin
                o_reg_address = (r_upper ? UPPER_BASE : 4'd0) + 4'd4;
                o_reg_data    = r_pat[3];
            end
            default: begin
                o_reg_address = ADDR_SHUTDOWN;
                o_reg_data    = DATA_SHUTDOWN;
            end
        endcase
    end

    // The last word always targets the thousands digit register
    a_last_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_word) |-> (o_reg_address == 4'd4 || o_reg_address == 4'd8))
        else $error("last word not on a thousands digit register");

    // A frame, once started, keeps going until its last word
    a_frame_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_word) |=> o_valid)
        else $error("frame broken off before its last word");

    // A new frame always starts with the shutdown word
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_word) |=> (!o_valid || o_reg_address == ADDR_SHUTDOWN))
        else $error("frame did not start with the shutdown word");

    // The units digit is never blanked
    a_units_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cnt == SLOT_UNITS) |-> (o_reg_data != SEG_BLANK))
        else $error("units digit blanked");

endmodule
